@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL files.
// Define ASSERT_OFF to compile every assertion out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property checked at each rising edge of clk_s, disabled while rst_s is high.
`define ASSERT_AT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// Same, on the module's own clk and rst.
`define ASSERT_CLK(lbl, prop, msg) \
  `ASSERT_AT(lbl, clk, rst, prop, msg)

`else

`define ASSERT_AT(lbl, clk_s, rst_s, prop, msg)
`define ASSERT_CLK(lbl, prop, msg)

`endif

`endif

@@ hw/rtl/lsfb_pkg.sv @@
package lsfb_pkg;

  // Default sizes.
  localparam int MAX_CHANNEL_COUNT_DEF = 512;
  localparam int MAX_TRAILER_BYTES_DEF = 8;

  // Descriptor queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;

  // Register file: six 64-bit registers at byte addresses 8*i.
  localparam int CFG_ADDR_W = 6;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [2:0] {
    REG_FRAME_MODE    = 3'd0,
    REG_CHANNEL_COUNT = 3'd1,
    REG_HEADER_LENGTH = 3'd2,
    REG_HEADER_BYTES  = 3'd3,
    REG_FOOTER_LENGTH = 3'd4,
    REG_FOOTER_BYTES  = 3'd5
  } reg_idx_t;

  // Frame modes.
  localparam logic [1:0] MODE_DMX      = 2'd0;
  localparam logic [1:0] MODE_RENARD   = 2'd1;
  localparam logic [1:0] MODE_GENERIC  = 2'd2;
  localparam logic [1:0] MODE_RESERVED = 2'd3;

  // Line byte values.
  localparam logic [7:0] DMX_START_CODE    = 8'h00;
  localparam logic [7:0] RENARD_SYNC       = 8'h7E;
  localparam logic [7:0] RENARD_DATA_START = 8'h80;
  localparam logic [7:0] RENARD_ESC        = 8'h7F;
  localparam logic [7:0] RENARD_ESC_LOW    = 8'h7D;
  localparam logic [7:0] RENARD_ESC_HIGH   = 8'h7F;
  localparam logic [7:0] RENARD_ESC_OFFSET = 8'h4E;

  typedef struct packed {
    logic       frame_start;
    logic [7:0] intensity;
  } item_t;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       run_last;
    logic       frame_done;
  } result_t;

  typedef struct packed {
    logic [1:0]  frame_mode;
    logic [9:0]  channel_count;
    logic [3:0]  header_length;
    logic [63:0] header_bytes;
    logic [3:0]  footer_length;
    logic [63:0] footer_bytes;
  } cfg_t;

  // Preamble that precedes the channel byte of an item.
  typedef enum logic [1:0] {
    PRE_NONE,
    PRE_DMX,
    PRE_RENARD,
    PRE_HEADER
  } pre_t;

  // Work for the back end: everything one input item turns into.
  typedef struct packed {
    pre_t       pre;
    logic       esc;
    logic [7:0] intensity;
    logic       footer;
    logic       done;
  } desc_t;

endpackage

@@ hw/rtl/lsfb_queue.sv @@
`include "assert_macros.svh"

module lsfb_queue
  import lsfb_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  desc_t push_data,
  output logic  full,
  input  logic  pop,
  output desc_t pop_data,
  output logic  not_empty
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  desc_t         entries [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == CW'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = entries[rd_ptr];

  // Storage is written at the tail only.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_CLK(queue_no_overflow, (count <= CW'(QUEUE_DEPTH)) && !(push && full && !pop), "descriptor queue overflow")

endmodule

@@ hw/rtl/lsfb_front.sv @@
`include "assert_macros.svh"

module lsfb_front
  import lsfb_pkg::*;
#(
  parameter int MAX_CHANNEL_COUNT = MAX_CHANNEL_COUNT_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  item_valid,
  output logic  item_stall,
  input  item_t item,
  output logic  push,
  output desc_t push_data,
  input  logic  q_full
);

  localparam int LEFT_W = $clog2(MAX_CHANNEL_COUNT + 1);

  logic              frame_active;
  logic              frame_active_next;
  logic [LEFT_W-1:0] channels_left;
  logic [LEFT_W-1:0] channels_left_next;
  logic              accept;
  logic [31:0]       count_clamped;
  logic [LEFT_W-1:0] count_now;
  logic              esc_hit;

  // The front stalls only when the queue has no room for a descriptor.
  assign item_stall = q_full;
  assign accept     = item_valid && !item_stall;

  // Classify the item and work out the frame state it leaves behind.
  always_comb begin
    count_clamped = 32'(cfg.channel_count);
    if (count_clamped == 32'd0) begin
      count_clamped = 32'd1;
    end
    if (count_clamped > 32'(MAX_CHANNEL_COUNT)) begin
      count_clamped = 32'(MAX_CHANNEL_COUNT);
    end
    count_now = item.frame_start ? count_clamped[LEFT_W-1:0] : channels_left;

    esc_hit = (cfg.frame_mode == MODE_RENARD) &&
              (item.intensity >= RENARD_ESC_LOW) &&
              (item.intensity <= RENARD_ESC_HIGH);

    push_data.pre = PRE_NONE;
    if (item.frame_start) begin
      unique case (cfg.frame_mode)
        MODE_DMX:     push_data.pre = PRE_DMX;
        MODE_RENARD:  push_data.pre = PRE_RENARD;
        MODE_GENERIC: push_data.pre = PRE_HEADER;
        default:      push_data.pre = PRE_NONE;
      endcase
    end
    push_data.esc       = esc_hit;
    push_data.intensity = item.intensity;
    push_data.done      = (count_now == LEFT_W'(1));
    push_data.footer    = push_data.done && (cfg.frame_mode == MODE_GENERIC);

    push               = 1'b0;
    frame_active_next  = frame_active;
    channels_left_next = channels_left;
    if (accept) begin
      if (cfg.frame_mode == MODE_RESERVED) begin
        frame_active_next  = 1'b0;
        channels_left_next = '0;
      end else if (item.frame_start || frame_active) begin
        push               = 1'b1;
        channels_left_next = count_now - 1'b1;
        frame_active_next  = !push_data.done;
      end
    end
  end

  // Frame state.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_active  <= 1'b0;
      channels_left <= '0;
    end else begin
      frame_active  <= frame_active_next;
      channels_left <= channels_left_next;
    end
  end

  `ASSERT_CLK(front_active_has_count, frame_active == (channels_left != '0), "frame state and channel count disagree")

endmodule

@@ hw/rtl/lsfb_back.sv @@
`include "assert_macros.svh"

module lsfb_back
  import lsfb_pkg::*;
#(
  parameter int MAX_TRAILER_BYTES = MAX_TRAILER_BYTES_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    q_valid,
  input  desc_t   q_data,
  output logic    pop,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  typedef enum logic [1:0] {
    PH_PRE,
    PH_DATA,
    PH_POST
  } phase_t;

  phase_t      phase;
  phase_t      phase_next;
  desc_t       cur;
  logic        cur_valid;
  logic [2:0]  idx;
  logic [2:0]  idx_next;
  logic [3:0]  hdr_len;
  logic [3:0]  ftr_len;
  logic [3:0]  cur_pre_len;
  logic [3:0]  new_pre_len;
  logic        can_emit;
  logic        step;
  logic        item_end;
  logic [7:0]  line;

  function automatic logic [3:0] clamp_len(logic [3:0] len);
    if (32'(len) > 32'(MAX_TRAILER_BYTES)) begin
      return 4'(MAX_TRAILER_BYTES);
    end
    return len;
  endfunction

  function automatic logic [3:0] pre_len(pre_t kind, logic [3:0] header_len);
    logic [3:0] len;
    unique case (kind)
      PRE_DMX:    len = 4'd1;
      PRE_RENARD: len = 4'd2;
      PRE_HEADER: len = header_len;
      default:    len = 4'd0;
    endcase
    return len;
  endfunction

  assign hdr_len     = clamp_len(cfg.header_length);
  assign ftr_len     = clamp_len(cfg.footer_length);
  assign cur_pre_len = pre_len(cur.pre, hdr_len);
  assign new_pre_len = pre_len(q_data.pre, hdr_len);

  // A byte moves into the output register when it is empty or being taken.
  assign can_emit = !result_valid || !result_stall;
  assign step     = cur_valid && can_emit;
  assign pop      = q_valid && (!cur_valid || (step && item_end));

  // Byte at the current position and the position after it.
  always_comb begin
    line       = DMX_START_CODE;
    item_end   = 1'b0;
    phase_next = phase;
    idx_next   = idx + 3'd1;
    unique case (phase)
      PH_PRE: begin
        case (cur.pre)
          PRE_DMX:    line = DMX_START_CODE;
          PRE_RENARD: line = (idx == 3'd0) ? RENARD_SYNC : RENARD_DATA_START;
          default:    line = cfg.header_bytes[{idx, 3'b000} +: 8];
        endcase
        if ((4'(idx) + 4'd1) == cur_pre_len) begin
          phase_next = PH_DATA;
          idx_next   = '0;
        end
      end
      PH_DATA: begin
        if (idx == 3'd0) begin
          line = cur.esc ? RENARD_ESC : cur.intensity;
        end else begin
          line = cur.intensity - RENARD_ESC_OFFSET;
        end
        if (!cur.esc || (idx != 3'd0)) begin
          if (cur.footer && (ftr_len != 4'd0)) begin
            phase_next = PH_POST;
            idx_next   = '0;
          end else begin
            item_end = 1'b1;
          end
        end
      end
      PH_POST: begin
        line = cfg.footer_bytes[{idx, 3'b000} +: 8];
        if ((4'(idx) + 4'd1) == ftr_len) begin
          item_end = 1'b1;
        end
      end
      default: begin
        item_end = 1'b1;
      end
    endcase
  end

  // Sequencer state and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_PRE;
      idx          <= '0;
      cur_valid    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (can_emit) begin
        result_valid <= cur_valid;
      end
      if (step) begin
        result.line_byte  <= line;
        result.run_last   <= item_end;
        result.frame_done <= item_end && cur.done;
        phase             <= phase_next;
        idx               <= idx_next;
        if (item_end) begin
          cur_valid <= 1'b0;
        end
      end
      if (pop) begin
        cur       <= q_data;
        cur_valid <= 1'b1;
        idx       <= '0;
        phase     <= (new_pre_len != 4'd0) ? PH_PRE : PH_DATA;
      end
    end
  end

  `ASSERT_CLK(back_done_is_last, result_valid && result.frame_done |-> result.run_last, "frame end not on last byte of item")
  `ASSERT_CLK(back_footer_only_at_end, cur_valid && (phase == PH_POST) |-> cur.footer && cur.done, "footer sent for an item that does not end a frame")

endmodule

@@ hw/rtl/lighting_serial_frame_builder.sv @@
// Lighting serial frame builder. Each input transfer carries one channel
// intensity byte; each output transfer carries one byte for the serial line.
// In DMX mode a start code of 0x00 precedes the first channel, in Renard mode
// a sync and a data-start byte precede it and channel values 0x7D to 0x7F go
// out escaped as two bytes, and in generic mode configured header bytes
// precede the first channel and footer bytes follow the last. Frame_start on
// an item opens a new frame and aborts one in progress; items outside a frame,
// and all items in the reserved mode, are dropped. An input item is taken when
// the queue has room and is queued as a descriptor (four deep); the output
// sequencer sends one byte per cycle while the receiver does not stall; an item
// causes one to seventeen bytes, which pass through the current-item register
// and the output register. Run_last marks the last byte of each item and
// frame_done the last byte of a frame. Registers sit at byte address 8*i in
// the order frame_mode, channel_count, header_length, header_bytes,
// footer_length, footer_bytes; write them only while the block is idle.
module lighting_serial_frame_builder
  import lsfb_pkg::*;
#(
  parameter int MAX_CHANNEL_COUNT = MAX_CHANNEL_COUNT_DEF,
  parameter int MAX_TRAILER_BYTES = MAX_TRAILER_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  item_t                 item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result
);

  cfg_t     cfg;
  reg_idx_t reg_sel;
  logic     cfg_write;
  logic     push;
  desc_t    push_data;
  logic     q_full;
  logic     pop;
  desc_t    q_data;
  logic     q_valid;

  assign pready    = 1'b1;
  assign reg_sel   = reg_idx_t'(paddr[CFG_ADDR_W-1:3]);
  assign cfg_write = psel && penable && pwrite && pready;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_mode    <= MODE_DMX;
      cfg.channel_count <= 10'd512;
      cfg.header_length <= '0;
      cfg.header_bytes  <= '0;
      cfg.footer_length <= '0;
      cfg.footer_bytes  <= '0;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_FRAME_MODE:    cfg.frame_mode    <= pwdata[1:0];
        REG_CHANNEL_COUNT: cfg.channel_count <= pwdata[9:0];
        REG_HEADER_LENGTH: cfg.header_length <= pwdata[3:0];
        REG_HEADER_BYTES:  cfg.header_bytes  <= pwdata;
        REG_FOOTER_LENGTH: cfg.footer_length <= pwdata[3:0];
        REG_FOOTER_BYTES:  cfg.footer_bytes  <= pwdata;
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (reg_sel)
      REG_FRAME_MODE:    prdata = CFG_DATA_W'(cfg.frame_mode);
      REG_CHANNEL_COUNT: prdata = CFG_DATA_W'(cfg.channel_count);
      REG_HEADER_LENGTH: prdata = CFG_DATA_W'(cfg.header_length);
      REG_HEADER_BYTES:  prdata = cfg.header_bytes;
      REG_FOOTER_LENGTH: prdata = CFG_DATA_W'(cfg.footer_length);
      REG_FOOTER_BYTES:  prdata = cfg.footer_bytes;
      default:           prdata = '0;
    endcase
  end

  lsfb_front #(
    .MAX_CHANNEL_COUNT(MAX_CHANNEL_COUNT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item      (item),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  lsfb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .full     (q_full),
    .pop      (pop),
    .pop_data (q_data),
    .not_empty(q_valid)
  );

  lsfb_back #(
    .MAX_TRAILER_BYTES(MAX_TRAILER_BYTES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_valid     (q_valid),
    .q_data      (q_data),
    .pop         (pop),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

endmodule

@@ dv/tb.sv @@
module tb;
  import lsfb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int HOLD_ITEMS     = 12;
  localparam int SETTLE_CYCLES  = 16;
  localparam int PHASE_COUNT    = 4;
  localparam int PHASE_TARGET   = 8;

  // Predicts the line bytes of every channel transfer and checks them in order.
  class frame_scoreboard;
    cfg_t    regs;
    bit      frame_open;
    int      channels_left;
    result_t run_bytes[$];
    result_t line_q[$];
    int      errors;
    int      items_taken;
    int      items_with_bytes;
    int      bytes_checked;
    int      frames_closed;
    int      longest_run;

    function new();
      regs = '0;
      regs.channel_count = 10'd512;
      frame_open = 1'b0;
      channels_left = 0;
      errors = 0;
      items_taken = 0;
      items_with_bytes = 0;
      bytes_checked = 0;
      frames_closed = 0;
      longest_run = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [63:0] v);
      case (idx)
        REG_FRAME_MODE:    regs.frame_mode = v[1:0];
        REG_CHANNEL_COUNT: regs.channel_count = v[9:0];
        REG_HEADER_LENGTH: regs.header_length = v[3:0];
        REG_HEADER_BYTES:  regs.header_bytes = v;
        REG_FOOTER_LENGTH: regs.footer_length = v[3:0];
        REG_FOOTER_BYTES:  regs.footer_bytes = v;
        default: ;
      endcase
    endfunction

    function logic [63:0] reg_value(reg_idx_t idx);
      case (idx)
        REG_FRAME_MODE:    return 64'(regs.frame_mode);
        REG_CHANNEL_COUNT: return 64'(regs.channel_count);
        REG_HEADER_LENGTH: return 64'(regs.header_length);
        REG_HEADER_BYTES:  return regs.header_bytes;
        REG_FOOTER_LENGTH: return 64'(regs.footer_length);
        REG_FOOTER_BYTES:  return regs.footer_bytes;
        default:           return '0;
      endcase
    endfunction

    // Channel count as the block latches it at frame start.
    function int frame_length();
      int cc;
      cc = regs.channel_count;
      if (cc < 1) cc = 1;
      if (cc > MAX_CHANNEL_COUNT_DEF) cc = MAX_CHANNEL_COUNT_DEF;
      return cc;
    endfunction

    function void add_byte(logic [7:0] b);
      result_t r;
      r = '0;
      r.line_byte = b;
      run_bytes.push_back(r);
    endfunction

    function void add_trailer(logic [63:0] bytes, logic [3:0] len);
      int cnt;
      cnt = (len > MAX_TRAILER_BYTES_DEF) ? MAX_TRAILER_BYTES_DEF : int'(len);
      for (int i = 0; i < cnt; i++) add_byte(bytes[8*i +: 8]);
    endfunction

    // Works out the line bytes caused by one accepted channel transfer.
    function void take_channel(item_t it);
      logic [1:0] mode;
      bit         done;
      mode = regs.frame_mode;
      done = 1'b0;
      items_taken++;
      run_bytes.delete();
      if (mode == MODE_RESERVED) begin
        frame_open = 1'b0;
        channels_left = 0;
        return;
      end
      if (it.frame_start) begin
        // A new frame aborts any frame in progress, without a footer.
        channels_left = frame_length();
        frame_open = 1'b1;
        case (mode)
          MODE_DMX: add_byte(DMX_START_CODE);
          MODE_RENARD: begin
            add_byte(RENARD_SYNC);
            add_byte(RENARD_DATA_START);
          end
          default: add_trailer(regs.header_bytes, regs.header_length);
        endcase
      end else if (!frame_open) begin
        return;
      end
      // Renard escapes the three values that collide with its control bytes.
      if (mode == MODE_RENARD && it.intensity >= RENARD_ESC_LOW &&
          it.intensity <= RENARD_ESC_HIGH) begin
        add_byte(RENARD_ESC);
        add_byte(it.intensity - RENARD_ESC_OFFSET);
      end else begin
        add_byte(it.intensity);
      end
      if (channels_left > 0) channels_left--;
      if (channels_left == 0) begin
        frame_open = 1'b0;
        done = 1'b1;
        if (mode == MODE_GENERIC) add_trailer(regs.footer_bytes, regs.footer_length);
      end
      run_bytes[run_bytes.size()-1].run_last = 1'b1;
      run_bytes[run_bytes.size()-1].frame_done = done;
      if (run_bytes.size() > longest_run) longest_run = run_bytes.size();
      items_with_bytes++;
      foreach (run_bytes[i]) line_q.push_back(run_bytes[i]);
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    // Compares one output transfer with the oldest predicted line byte.
    task check_line_byte(result_t got);
      result_t want;
      if (line_q.size() == 0) begin
        report($sformatf("unexpected line byte %02h", got.line_byte));
        return;
      end
      want = line_q.pop_front();
      bytes_checked++;
      if (got.line_byte !== want.line_byte)
        report($sformatf("line_byte %02h, predicted %02h", got.line_byte, want.line_byte));
      if (got.run_last !== want.run_last)
        report($sformatf("run_last %b, predicted %b (byte %02h)",
                         got.run_last, want.run_last, want.line_byte));
      if (got.frame_done !== want.frame_done)
        report($sformatf("frame_done %b, predicted %b (byte %02h)",
                         got.frame_done, want.frame_done, want.line_byte));
      if (want.frame_done) frames_closed++;
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  item_valid = 1'b0;
  logic                  item_stall;
  item_t                 item = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_t               result;

  frame_scoreboard sb = new();

  int send_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  lighting_serial_frame_builder i_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #10 clk = ~clk;

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // Every output transfer is checked against the prediction.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_line_byte(result);
  end

  // The run is stopped when no transfer happens for too long.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one channel byte and waits for its transfer. Called and left at a
  // falling edge, so that valid stays high between back-to-back items.
  task automatic send_item(item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (item_stall);
    sb.take_channel(it);
    @(negedge clk);
  endtask

  task automatic send(bit s, logic [7:0] v);
    item_t it;
    it.frame_start = s;
    it.intensity = v;
    send_item(it);
  endtask

  // Waits until every predicted byte has gone out, then lets the block settle.
  task automatic wait_idle();
    item_valid <= 1'b0;
    while (sb.line_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Register write followed by a read back of the same register.
  task automatic cfg_write(reg_idx_t idx, logic [63:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, v);
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== sb.reg_value(idx))
      sb.report($sformatf("register %s reads %h, written %h", idx.name(), prdata,
                          sb.reg_value(idx)));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Intensities lean toward the Renard escape range.
  function automatic logic [7:0] pick_intensity();
    if ($urandom_range(3) == 0) return 8'($urandom_range(RENARD_ESC_HIGH, RENARD_ESC_LOW));
    return 8'($urandom_range(255));
  endfunction

  task automatic random_setup();
    int roll;
    logic [9:0] cc;
    roll = $urandom_range(99);
    if (roll < 10) cfg_write(REG_FRAME_MODE, 64'(MODE_RESERVED));
    else cfg_write(REG_FRAME_MODE, 64'($urandom_range(2)));
    roll = $urandom_range(99);
    if (roll < 55) cc = 10'($urandom_range(8, 1));
    else if (roll < 70) cc = 10'd0;
    else if (roll < 85) cc = 10'($urandom_range(40, 9));
    else if (roll < 90) cc = 10'd512;
    else cc = 10'($urandom_range(1023, 513));
    cfg_write(REG_CHANNEL_COUNT, 64'(cc));
    cfg_write(REG_HEADER_LENGTH, 64'($urandom_range(15)));
    cfg_write(REG_HEADER_BYTES, {$urandom, $urandom});
    cfg_write(REG_FOOTER_LENGTH, 64'($urandom_range(15)));
    cfg_write(REG_FOOTER_BYTES, {$urandom, $urandom});
  endtask

  // One stretch of stimulus: mostly whole frames, some cut short, some
  // overrunning their count, and some loose bytes.
  task automatic random_sequence();
    int flen;
    int n;
    int kind;
    flen = sb.frame_length();
    kind = $urandom_range(99);
    if (kind < 92) begin
      if (kind < 70) n = (flen > 40) ? $urandom_range(40, 1) : flen;
      else if (kind < 82) n = (flen > 1) ? $urandom_range((flen > 40) ? 40 : flen - 1, 1) : 1;
      else n = ((flen > 40) ? 40 : flen) + $urandom_range(3, 1);
      for (int i = 0; i < n; i++) send(i == 0, pick_intensity());
    end else begin
      n = $urandom_range(4, 1);
      for (int i = 0; i < n; i++) send($urandom_range(3) == 0, pick_intensity());
    end
  endtask

  task automatic run_phase(int target);
    int made0;
    int taken0;
    made0 = sb.items_with_bytes;
    taken0 = sb.items_taken;
    // Sometimes carry on the frame left open under the old settings.
    if ($urandom_range(9) < 3) begin
      send(1'b0, pick_intensity());
      send(1'b0, pick_intensity());
    end
    while (sb.items_with_bytes - made0 < target && sb.items_taken - taken0 < 3 * target)
      random_sequence();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: a stray byte, then a DMX frame left open.
    send(1'b0, 8'h12);
    send(1'b1, 8'h00);
    send(1'b0, 8'hFF);

    // Renard, switched while the DMX frame is still open; every escaped value.
    wait_idle();
    cfg_write(REG_FRAME_MODE, 64'(MODE_RENARD));
    cfg_write(REG_CHANNEL_COUNT, 64'd3);
    send(1'b0, 8'h7D);
    send(1'b1, 8'h7D);
    send(1'b0, 8'h7E);
    send(1'b0, 8'h7F);
    send(1'b0, 8'h7C);
    send(1'b1, 8'h80);
    send(1'b1, 8'h7C);
    send(1'b0, 8'h00);

    // Generic with full header, oversized footer length and a zero count.
    wait_idle();
    cfg_write(REG_FRAME_MODE, 64'(MODE_GENERIC));
    cfg_write(REG_CHANNEL_COUNT, 64'd0);
    cfg_write(REG_HEADER_LENGTH, 64'd8);
    cfg_write(REG_HEADER_BYTES, 64'h0123_4567_89AB_CDEF);
    cfg_write(REG_FOOTER_LENGTH, 64'd15);
    cfg_write(REG_FOOTER_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
    send(1'b1, 8'h7E);
    wait_idle();
    cfg_write(REG_CHANNEL_COUNT, 64'd2);
    cfg_write(REG_HEADER_LENGTH, 64'd0);
    cfg_write(REG_FOOTER_LENGTH, 64'd0);
    send(1'b1, 8'h01);
    send(1'b0, 8'h02);

    // Reserved mode drops everything and closes the frame.
    wait_idle();
    cfg_write(REG_FRAME_MODE, 64'(MODE_RESERVED));
    send(1'b1, 8'hAA);
    send(1'b0, 8'h55);
    wait_idle();
    cfg_write(REG_FRAME_MODE, 64'(MODE_DMX));
    send(1'b0, 8'h33);

    // One full-size DMX frame with an oversized count, plus one byte beyond it.
    wait_idle();
    cfg_write(REG_CHANNEL_COUNT, 64'd1023);
    for (int i = 0; i <= MAX_CHANNEL_COUNT_DEF; i++) send(i == 0, 8'($urandom_range(255)));

    // Random phases under changing settings and pacing.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      wait_idle();
      random_setup();
      case (p % 4)
        0: begin send_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin send_idle_pct = 54; rx_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  rx_stall_pct = 54; end
        default: begin send_idle_pct = 35; rx_stall_pct = 35; end
      endcase
      if (p == 2) begin
        // Long receiver hold-off while frame starts keep coming, then a full drain.
        if (sb.regs.frame_mode == MODE_RESERVED) cfg_write(REG_FRAME_MODE, 64'(MODE_DMX));
        @(posedge clk);
        hold_req = hold_req + 1;
        @(negedge clk);
        for (int i = 0; i < HOLD_ITEMS; i++) send(1'b1, pick_intensity());
        wait_idle();
        run_phase(PHASE_TARGET);
      end else begin
        run_phase(PHASE_TARGET);
      end
    end

    wait_idle();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (sb.line_q.size() != 0)
      sb.report($sformatf("%0d predicted line bytes never arrived", sb.line_q.size()));
    $display("covered %0d channel transfers (%0d with output), %0d line bytes, %0d frames",
             sb.items_taken, sb.items_with_bytes, sb.bytes_checked, sb.frames_closed);
    $display("DMX, Renard, generic and reserved modes; longest run %0d bytes; %0d-cycle hold-off",
             sb.longest_run, HOLD_CYCLES);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ lighting_serial_frame_builder.f @@
+incdir+hw/rtl
hw/rtl/lsfb_pkg.sv
hw/rtl/lsfb_queue.sv
hw/rtl/lsfb_front.sv
hw/rtl/lsfb_back.sv
hw/rtl/lighting_serial_frame_builder.sv
dv/tb.sv
